>>> rtl/gmvf_pkg.sv
// Shared widths, register indexes and reset values for the gated majority vote filter.
// No dependencies; every other file imports this package.
`default_nettype none

package gmvf_pkg;

	// Field widths
	localparam int unsigned RMS_W      = 16;
	localparam int unsigned CONF_W     = 16;
	localparam int unsigned CLASS_W    = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	// Number of distinct labels a class field can carry
	localparam int unsigned LABEL_CLASSES = 1 << CLASS_W;

	// Configuration register indexes
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_ACT_THR  = 2'd0;
	localparam cfg_idx_t REG_CONF_THR = 2'd1;
	localparam cfg_idx_t REG_REST_CLS = 2'd2;

	// Register reset values
	localparam logic [RMS_W-1:0]   ACT_THR_RST  = 16'd256;
	localparam logic [CONF_W-1:0]  CONF_THR_RST = 16'd32768;
	localparam logic [CLASS_W-1:0] REST_CLS_RST = 2'd0;

	typedef logic [CLASS_W-1:0] class_t;

endpackage : gmvf_pkg

`default_nettype wire

>>> rtl/gmvf_item_if.sv
// Input tick channel: valid/ready handshake with the inference tick fields.
// Depends on gmvf_pkg.
`default_nettype none

interface gmvf_item_if;
	import gmvf_pkg::*;

	logic                valid;
	logic                ready;
	logic                window_ready;
	logic [RMS_W-1:0]    activity_rms;
	class_t              pred_class;
	logic [CONF_W-1:0]   confidence;

	modport source (output valid, window_ready, activity_rms, pred_class, confidence,
		input ready);
	modport sink (input valid, window_ready, activity_rms, pred_class, confidence,
		output ready);

endinterface : gmvf_item_if

`default_nettype wire

>>> rtl/gmvf_result_if.sv
// Result channel: valid/ready handshake with the voted class and gated intent.
// Depends on gmvf_pkg.
`default_nettype none

interface gmvf_result_if;
	import gmvf_pkg::*;

	logic   valid;
	logic   ready;
	class_t voted_class;
	class_t gated_intent;

	modport source (output valid, voted_class, gated_intent, input ready);
	modport sink (input valid, voted_class, gated_intent, output ready);

endinterface : gmvf_result_if

`default_nettype wire

>>> rtl/gmvf_cfg_if.sv
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on gmvf_pkg.
`default_nettype none

interface gmvf_cfg_if;
	import gmvf_pkg::*;

	logic                  valid;
	logic                  ready;
	cfg_idx_t              index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);

endinterface : gmvf_cfg_if

`default_nettype wire

>>> rtl/gated_majority_vote_filter_core.sv
// Gated majority vote filter: threshold gating of classifier ticks and a sliding vote.
// An accepted tick passes through the input register, then the result register, to result valid.
// One tick per cycle unless stalled by result.ready; counters and result load in the same cycle.
// Ticks with window_ready low are dropped at the input register and give no result.
// Reset clears the vote window, counters and fill level, and loads register reset values.
// Depends on gmvf_pkg, the three channel interfaces and gmvf_vote.
`default_nettype none

module gated_majority_vote_filter_core #(
	parameter int unsigned VOTE_DEPTH  = 8,
	parameter int unsigned CLASS_COUNT = 4
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	gmvf_item_if.sink     item,
	gmvf_result_if.source result,
	gmvf_cfg_if.sink      cfg
);
	import gmvf_pkg::*;

	logic [RMS_W-1:0]  act_thr_q;
	logic [CONF_W-1:0] conf_thr_q;
	class_t            rest_cls_q;

	logic              valid_s1;
	logic [RMS_W-1:0]  rms_s1;
	class_t            cls_s1;
	logic [CONF_W-1:0] conf_s1;

	logic              out_valid_q;
	class_t            voted_q;
	class_t            intent_q;

	logic              advance;
	logic              push;
	class_t            intent;
	class_t            winner;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_thr_q  <= ACT_THR_RST;
			conf_thr_q <= CONF_THR_RST;
			rest_cls_q <= REST_CLS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ACT_THR:  act_thr_q  <= cfg.data[RMS_W-1:0];
				REG_CONF_THR: conf_thr_q <= cfg.data[CONF_W-1:0];
				REG_REST_CLS: rest_cls_q <= cfg.data[CLASS_W-1:0];
				default:      ;
			endcase
		end
	end

	// Flow control: the result register frees when empty or taken
	assign advance    = !out_valid_q || result.ready;
	assign item.ready = !valid_s1 || advance;
	assign push       = valid_s1 && advance;

	// Input register; drop ticks whose window is not full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= item.window_ready;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready && item.window_ready) begin
			rms_s1  <= item.activity_rms;
			cls_s1  <= item.pred_class;
			conf_s1 <= item.confidence;
		end
	end

	// Gate the classifier result by activity and confidence
	assign intent = ((rms_s1 < act_thr_q) || (conf_s1 < conf_thr_q)) ? rest_cls_q : cls_s1;

	gmvf_vote #(
		.VOTE_DEPTH  (VOTE_DEPTH),
		.CLASS_COUNT (CLASS_COUNT)
	) u_vote (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.label  (intent),
		.winner (winner)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			voted_q  <= winner;
			intent_q <= intent;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.voted_class  = voted_q;
	assign result.gated_intent = intent_q;

	// A tick moving out of the input register always lands in the result register
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> out_valid_q)
		else $error("pushed tick did not reach the result register");

	// Low activity forces the rest class
	a_act_gate: assert property (@(posedge clk) disable iff (!arst_n)
		(push && (rms_s1 < act_thr_q)) |=> (intent_q == $past(rest_cls_q)))
		else $error("low activity tick was not gated to rest");

	// A tick with an unfilled window never occupies the input register
	a_skip_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && !item.window_ready) |=> !valid_s1)
		else $error("skipped tick entered the input register");

endmodule : gated_majority_vote_filter_core

`default_nettype wire

>>> rtl/gmvf_vote.sv
// Vote window: shift line of the last VOTE_DEPTH labels, per-class counters and argmax.
// Depends on gmvf_pkg; the winner output reflects the counts after the current push.
`default_nettype none

module gmvf_vote #(
	parameter int unsigned VOTE_DEPTH  = 8,
	parameter int unsigned CLASS_COUNT = 4
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire gmvf_pkg::class_t label,
	output gmvf_pkg::class_t     winner
);
	import gmvf_pkg::*;

	localparam int unsigned CNT_W   = $clog2(VOTE_DEPTH + 1);
	// Labels at or above CLASS_COUNT are never counted; labels never exceed LABEL_CLASSES-1
	localparam int unsigned NUM_CNT = (CLASS_COUNT < LABEL_CLASSES) ? CLASS_COUNT
		: LABEL_CLASSES;

	class_t           ring_q [VOTE_DEPTH];
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] cnt_q [NUM_CNT];
	logic [CNT_W-1:0] cnt_d [NUM_CNT];
	logic             full;
	class_t           oldest;

	assign full   = (fill_q == CNT_W'(VOTE_DEPTH));
	assign oldest = ring_q[VOTE_DEPTH-1];

	// Add the new label, drop the label leaving a full window
	always_comb begin
		for (int c = 0; c < NUM_CNT; c++) begin
			cnt_d[c] = cnt_q[c]
				+ CNT_W'(push && (label == CLASS_W'(c)))
				- CNT_W'(push && full && (oldest == CLASS_W'(c)));
		end
	end

	// Pick the highest count, lowest class on tie
	always_comb begin
		winner = '0;
		for (int c = 1; c < NUM_CNT; c++) begin
			if (cnt_d[c] > cnt_d[winner])
				winner = CLASS_W'(c);
		end
	end

	// Advance the label shift line and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VOTE_DEPTH; i++)
				ring_q[i] <= '0;
			fill_q <= '0;
		end else if (push) begin
			ring_q[0] <= label;
			for (int i = 1; i < VOTE_DEPTH; i++)
				ring_q[i] <= ring_q[i-1];
			if (!full)
				fill_q <= fill_q + CNT_W'(1);
		end
	end

	// Hold the per-class counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CNT; c++)
				cnt_q[c] <= '0;
		end else if (push) begin
			for (int c = 0; c < NUM_CNT; c++)
				cnt_q[c] <= cnt_d[c];
		end
	end

endmodule : gmvf_vote

`default_nettype wire
